### hdl/assert_macros.svh
// Assertion macros for the RTL that checks itself.
// No dependencies; each macro samples on clk and is disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/adcscan_pkg.sv
// Shared opcodes, constants and inter-module structs for the converter scanner.
// No dependencies.
package adcscan_pkg;

  // Item opcodes
  localparam logic [1:0] OP_CONV    = 2'd0;
  localparam logic [1:0] OP_ARM     = 2'd1;
  localparam logic [1:0] OP_RD_SLOT = 2'd2;
  localparam logic [1:0] OP_RD_BYTE = 2'd3;

  // Capture store layout and byte constants
  localparam int         HEADER_LEN   = 1;
  localparam logic [7:0] HEADER_BYTE  = 8'h4C;
  localparam logic [7:0] BYTE_SAT     = 8'hFF;
  localparam logic [9:0] LEVEL_THRESH = 10'd256;

  // Capture memory read issued when an item is taken in
  typedef struct packed {
    logic       valid;
    logic [7:0] index;
  } cap_issue_t;

  // Item being completed in the execute stage
  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic       on_cap;
    logic [9:0] sample;
    logic [15:0] tick;
    logic [7:0] divider;
    logic [7:0] index;
  } cap_step_t;

  // Capture part of the result item
  typedef struct packed {
    logic        byte_written;
    logic [7:0]  capture_byte;
    logic        capture_done;
    logic [15:0] elapsed_ticks;
    logic        capture_filled;
  } cap_res_t;

endpackage

### hdl/adcscan_if.sv
// Valid/ready channel interfaces for the scanner's input and result items.
// No dependencies.
interface adcscan_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [9:0]  sample;
  logic [15:0] tick;
  logic [5:0]  hold_mask;
  logic [7:0]  divider;
  logic [7:0]  index;

  modport source (output valid, op, sample, tick, hold_mask, divider, index, input ready);
  modport sink   (input valid, op, sample, tick, hold_mask, divider, index, output ready);
endinterface

interface adcscan_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  slot;
  logic [9:0]  value;
  logic [5:0]  level_bits;
  logic [2:0]  next_slot;
  logic        byte_written;
  logic [7:0]  capture_byte;
  logic        capture_done;
  logic [15:0] elapsed_ticks;
  logic        capture_filled;

  modport source (output valid, slot, value, level_bits, next_slot, byte_written,
                  capture_byte, capture_done, elapsed_ticks, capture_filled,
                  input ready);
  modport sink   (input valid, slot, value, level_bits, next_slot, byte_written,
                  capture_byte, capture_done, elapsed_ticks, capture_filled,
                  output ready);
endinterface

### hdl/adc_scan_with_decimated_capture_unit.sv
// Top level of the round-robin converter scanner with decimated capture.
// Depends on adcscan_pkg, adcscan_if, adcscan_capture and assert_macros.svh.
//
//  channel | dir | handshake          | payload
//  in_ch   | in  | valid/ready        | op, sample, tick, hold_mask, divider, index
//  out_ch  | out | valid/ready        | slot, value, level_bits, next_slot, capture fields
//
// Each item reads the slot and capture memories at intake, then in execute the two
// memories are written back and the output register loads.
// One item a cycle is sustained while the output is not stalled; same-entry clashes
// between a read and a write back are forwarded. rst clears all control state.
// A stalled output holds its item; the execute stage and intake wait behind it.
`include "assert_macros.svh"

module adc_scan_with_decimated_capture_unit
  import adcscan_pkg::*;
#(
  parameter int NUM_SLOTS    = 6,
  parameter int CAPTURE_SLOT = 2,
  parameter int CAPTURE_LEN  = 128
) (
  input logic           clk,
  input logic           rst,
  adcscan_in_if.sink    in_ch,
  adcscan_out_if.source out_ch
);

  localparam int       SW     = $clog2(NUM_SLOTS);
  localparam int       XW     = (SW > 3) ? SW : 3;
  localparam int       LW     = (NUM_SLOTS > 6) ? NUM_SLOTS : 6;
  localparam bit       CAP_OK = (CAPTURE_SLOT < NUM_SLOTS);
  localparam logic [SW-1:0] CAP_IDX = SW'(CAPTURE_SLOT);

  logic                 accept;
  logic                 p_adv;
  logic                 step;

  // Scan state
  logic [SW-1:0]        current_slot;
  logic [SW-1:0]        slot_wrap;
  logic [NUM_SLOTS-1:0] levels;
  logic [NUM_SLOTS-1:0] levels_next;

  // Execute stage register
  logic                 p_valid;
  logic [1:0]           p_op;
  logic [9:0]           p_sample;
  logic [15:0]          p_tick;
  logic [5:0]           p_hold_mask;
  logic [7:0]           p_divider;
  logic [7:0]           p_index;
  logic [SW-1:0]        p_slot;
  logic                 p_rd_ok;

  // Slot value memory
  logic [9:0]           sv_mem [NUM_SLOTS];
  logic [SW-1:0]        sv_raddr;
  logic [9:0]           sv_rd_data;
  logic                 sv_fwd;
  logic [9:0]           sv_fwd_data;
  logic [9:0]           sv_rd;
  logic                 sv_we;
  logic                 held;
  logic                 rd_ok;

  // Capture part
  cap_issue_t           cap_issue;
  cap_step_t            cap_step;
  cap_res_t             cap_res;

  // Output register
  logic                 o_valid;
  logic [2:0]           o_slot;
  logic [9:0]           o_value;
  logic [5:0]           o_level_bits;
  logic [2:0]           o_next_slot;
  cap_res_t             o_cap;

  logic [9:0]           value_c;
  logic [XW-1:0]        slot_ext;
  logic [XW-1:0]        next_ext;
  logic [LW-1:0]        lv_ext;

  // Handshake
  assign p_adv       = !o_valid || out_ch.ready;
  assign in_ch.ready = !p_valid || p_adv;
  assign accept      = in_ch.valid && in_ch.ready;
  assign step        = p_valid && p_adv;

  assign slot_wrap = (current_slot == SW'(NUM_SLOTS - 1)) ? '0 : current_slot + SW'(1);
  assign rd_ok     = (in_ch.index < 8'(NUM_SLOTS));
  assign sv_raddr  = (in_ch.op == OP_CONV) ? current_slot : in_ch.index[SW-1:0];

  // Intake: latch the item; a conversion advances the scan pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid      <= 1'b0;
      current_slot <= '0;
    end else begin
      if (accept) begin
        p_valid <= 1'b1;
      end else if (p_adv) begin
        p_valid <= 1'b0;
      end
      if (accept && (in_ch.op == OP_CONV)) begin
        current_slot <= slot_wrap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_op        <= in_ch.op;
      p_sample    <= in_ch.sample;
      p_tick      <= in_ch.tick;
      p_hold_mask <= in_ch.hold_mask;
      p_divider   <= in_ch.divider;
      p_index     <= in_ch.index;
      p_rd_ok     <= rd_ok;
      if (in_ch.op == OP_CONV) begin
        p_slot <= current_slot;
      end else if ((in_ch.op == OP_RD_SLOT) && rd_ok) begin
        p_slot <= in_ch.index[SW-1:0];
      end else begin
        p_slot <= '0;
      end
    end
  end

  // Hold bit of the measured slot; slots above the mask width are never held
  always_comb begin
    held = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if ((i < NUM_SLOTS) && (p_slot == SW'(i))) begin
        held = p_hold_mask[i];
      end
    end
  end

  assign sv_we = step && (p_op == OP_CONV) && !held;
  assign sv_rd = sv_fwd ? sv_fwd_data : sv_rd_data;

  // Slot value memory: read at intake, write back in execute
  always_ff @(posedge clk) begin
    if (accept) begin
      sv_rd_data  <= sv_mem[sv_raddr];
      sv_fwd      <= sv_we && (p_slot == sv_raddr);
      sv_fwd_data <= p_sample;
    end
    if (sv_we) begin
      sv_mem[p_slot] <= p_sample;
    end
  end

  // Level bits after this item
  always_comb begin
    levels_next = levels;
    if (step && (p_op == OP_CONV)) begin
      levels_next[p_slot] = (p_sample >= LEVEL_THRESH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= '0;
    end else begin
      levels <= levels_next;
    end
  end

  // Capture part
  assign cap_issue.valid = accept;
  assign cap_issue.index = in_ch.index;

  always_comb begin
    cap_step.valid   = step;
    cap_step.op      = p_op;
    cap_step.on_cap  = CAP_OK && (p_slot == CAP_IDX);
    cap_step.sample  = p_sample;
    cap_step.tick    = p_tick;
    cap_step.divider = p_divider;
    cap_step.index   = p_index;
  end

  adcscan_capture #(
    .CAPTURE_LEN (CAPTURE_LEN)
  ) u_capture (
    .clk   (clk),
    .rst   (rst),
    .issue (cap_issue),
    .step  (cap_step),
    .res   (cap_res)
  );

  // Result assembly
  always_comb begin
    case (p_op)
      OP_CONV:    value_c = held ? sv_rd : p_sample;
      OP_RD_SLOT: value_c = p_rd_ok ? sv_rd : 10'd0;
      default:    value_c = 10'd0;
    endcase
  end

  assign slot_ext = XW'(p_slot);
  assign next_ext = XW'(current_slot);
  assign lv_ext   = LW'(levels_next);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (step) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      o_slot       <= slot_ext[2:0];
      o_value      <= value_c;
      o_level_bits <= lv_ext[5:0];
      o_next_slot  <= next_ext[2:0];
      o_cap        <= cap_res;
    end
  end

  assign out_ch.valid          = o_valid;
  assign out_ch.slot           = o_slot;
  assign out_ch.value          = o_value;
  assign out_ch.level_bits     = o_level_bits;
  assign out_ch.next_slot      = o_next_slot;
  assign out_ch.byte_written   = o_cap.byte_written;
  assign out_ch.capture_byte   = o_cap.capture_byte;
  assign out_ch.capture_done   = o_cap.capture_done;
  assign out_ch.elapsed_ticks  = o_cap.elapsed_ticks;
  assign out_ch.capture_filled = o_cap.capture_filled;

  // Checks
  `ASSERT_SAME(a_done_wrote, o_valid && o_cap.capture_done, o_cap.byte_written && o_cap.capture_filled, "capture done without byte written and filled")
  `ASSERT_SAME(a_byte_only_conv, step && (p_op != OP_CONV), !cap_res.byte_written, "capture byte written by a non-conversion item")
  `ASSERT_NEXT(a_exec_drains, p_valid && !o_valid, o_valid, "execute stage did not drain into empty output register")

endmodule

### hdl/adcscan_capture.sv
// Decimated capture: capture byte memory, decimation state and elapsed-tick trailer.
// Depends on adcscan_pkg.
module adcscan_capture
  import adcscan_pkg::*;
#(
  parameter int CAPTURE_LEN = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  cap_issue_t issue,
  input  cap_step_t  step,
  output cap_res_t   res
);

  localparam int PW = (CAPTURE_LEN > 1) ? $clog2(CAPTURE_LEN) : 1;

  // Data bytes only; header is constant, trailer lives in registers
  logic [7:0]    mem [CAPTURE_LEN];
  logic [7:0]    rd_data;
  logic          fwd;
  logic [7:0]    fwd_data;

  logic [7:0]    decimation;
  logic [7:0]    dec_count;
  logic [PW-1:0] pos;
  logic [15:0]   start_tick;
  logic          filled;
  logic [7:0]    trail_lo;
  logic [7:0]    trail_hi;

  logic [PW-1:0] raddr;
  logic [7:0]    idx_off;
  logic          we;
  logic [PW-1:0] waddr;
  logic [7:0]    wdata;

  logic          is_conv;
  logic          armed;
  logic [7:0]    cnt_inc;
  logic          take;
  logic          first;
  logic          last;
  logic [15:0]   start_eff;
  logic [15:0]   elapsed;
  logic [7:0]    sat_byte;
  logic [7:0]    rbyte;
  logic          filled_next;

  // Read address: byte position less the header
  assign idx_off = issue.index - 8'(HEADER_LEN);
  assign raddr   = idx_off[PW-1:0];

  // Memory: read at issue, write at the end of execute, forward on a clash
  always_ff @(posedge clk) begin
    if (issue.valid) begin
      rd_data  <= mem[raddr];
      fwd      <= we && (waddr == raddr);
      fwd_data <= wdata;
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Decimation decision for the item in execute
  always_comb begin
    is_conv   = step.valid && (step.op == OP_CONV) && step.on_cap;
    armed     = (decimation != 8'd0) && !filled;
    cnt_inc   = dec_count + 8'd1;
    take      = is_conv && armed && (cnt_inc >= decimation);
    sat_byte  = (step.sample >= LEVEL_THRESH) ? BYTE_SAT : step.sample[7:0];
    first     = (pos == '0);
    last      = (pos == PW'(CAPTURE_LEN - 1));
    start_eff = first ? step.tick : start_tick;
    elapsed   = step.tick - start_eff;
    we        = take;
    waddr     = pos;
    wdata     = sat_byte;
  end

  // Byte read-back: header, data, trailer, else zero
  always_comb begin
    if (step.index < 8'(HEADER_LEN)) begin
      rbyte = HEADER_BYTE;
    end else if (step.index < 8'(HEADER_LEN + CAPTURE_LEN)) begin
      rbyte = fwd ? fwd_data : rd_data;
    end else if (step.index == 8'(HEADER_LEN + CAPTURE_LEN)) begin
      rbyte = trail_lo;
    end else if (step.index == 8'(HEADER_LEN + CAPTURE_LEN + 1)) begin
      rbyte = trail_hi;
    end else begin
      rbyte = 8'd0;
    end
  end

  // Filled flag after this item
  always_comb begin
    filled_next = filled;
    if (step.valid && (step.op == OP_ARM)) begin
      filled_next = 1'b0;
    end else if (take && last) begin
      filled_next = 1'b1;
    end
  end

  // Result fields
  always_comb begin
    res.byte_written   = take;
    res.capture_done   = take && last;
    res.elapsed_ticks  = (take && last) ? elapsed : 16'd0;
    res.capture_filled = filled_next;
    if (take) begin
      res.capture_byte = sat_byte;
    end else if (step.valid && (step.op == OP_RD_BYTE)) begin
      res.capture_byte = rbyte;
    end else begin
      res.capture_byte = 8'd0;
    end
  end

  // Capture state update
  always_ff @(posedge clk) begin
    if (rst) begin
      decimation <= 8'd0;
      dec_count  <= 8'd0;
      pos        <= '0;
      start_tick <= 16'd0;
      filled     <= 1'b0;
    end else begin
      filled <= filled_next;
      if (step.valid && (step.op == OP_ARM)) begin
        decimation <= step.divider;
      end else if (is_conv && !armed) begin
        pos       <= '0;
        dec_count <= 8'd0;
      end else if (is_conv) begin
        dec_count <= cnt_inc;
        if (take) begin
          dec_count <= 8'd0;
          if (first) begin
            start_tick <= step.tick;
          end
          if (last) begin
            pos        <= '0;
            decimation <= 8'd0;
          end else begin
            pos <= pos + PW'(1);
          end
        end
      end
    end
  end

  // Elapsed-tick trailer, little end first
  always_ff @(posedge clk) begin
    if (take && last) begin
      trail_lo <= elapsed[7:0];
      trail_hi <= elapsed[15:8];
    end
  end

endmodule
